// ===== src/skr_pkg.sv =====
// Shared types, codes and the candidate step function of the skyline allocator.
package skr_pkg;

    localparam int DIM_BITS   = 13;
    localparam int COORD_BITS = 12;
    localparam int AREA_BITS  = 25;

    localparam logic [DIM_BITS-1:0]  DIM_RESET = 13'd512;
    localparam logic [DIM_BITS-1:0]  DIM_MIN   = 13'd3;
    localparam logic [DIM_BITS-1:0]  DIM_MAX   = 13'd4096;
    localparam logic [AREA_BITS-1:0] AREA_MAX  = {AREA_BITS{1'b1}};

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Cell operation codes
    localparam logic [3:0] OP_HOLD    = 4'd0;
    localparam logic [3:0] OP_CLEAR   = 4'd1;
    localparam logic [3:0] OP_LOAD    = 4'd2;
    localparam logic [3:0] OP_SHIFT   = 4'd3;
    localparam logic [3:0] OP_INSERT  = 4'd4;
    localparam logic [3:0] OP_REMOVE  = 4'd5;
    localparam logic [3:0] OP_TRIM    = 4'd6;
    localparam logic [3:0] OP_MERGE_R = 4'd7;
    localparam logic [3:0] OP_MERGE_L = 4'd8;

    typedef struct packed {
        logic                action;
        logic [DIM_BITS-1:0] req_width;
        logic [DIM_BITS-1:0] req_height;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [COORD_BITS-1:0] region_x;
        logic [COORD_BITS-1:0] region_y;
        logic [AREA_BITS-1:0]  used_area;
    } out_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [DIM_BITS-1:0]   w;
    } seg_t;

    // Fit candidate that walks down the cell chain
    typedef struct packed {
        logic                  valid;
        logic                  done;
        logic                  fail;
        logic [COORD_BITS-1:0] y;
        logic signed [DIM_BITS:0] left;
        logic [COORD_BITS-1:0] sx;
        logic [DIM_BITS-1:0]   sw;
    } cand_t;

    typedef struct packed {
        logic [3:0]          op;
        logic [DIM_BITS-1:0] edge_pos;
        seg_t                new_seg;
        logic [DIM_BITS-1:0] req_w;
        logic [DIM_BITS-1:0] req_h;
        logic [DIM_BITS-1:0] aw;
        logic [DIM_BITS-1:0] ah;
    } cell_ctl_t;

    typedef struct packed {
        logic trim_hit;
        logic covered;
        logic eq_next;
        logic eq_best;
    } cell_flag_t;

    // Advance a candidate over one segment
    function automatic cand_t cand_step(cand_t c, seg_t s, logic sv,
                                        logic [DIM_BITS-1:0] h, logic [DIM_BITS-1:0] ah);
        cand_t                    r;
        logic [COORD_BITS-1:0]    ny;
        logic [DIM_BITS:0]        top;
        logic signed [DIM_BITS:0] nl;
        r   = c;
        ny  = (s.y > c.y) ? s.y : c.y;
        top = {2'b00, ny} + {1'b0, h};
        nl  = c.left - $signed({1'b0, s.w});
        if (c.valid && !c.done && !c.fail) begin
            if (!sv) begin
                r.fail = 1'b1;
            end else begin
                r.y    = ny;
                r.left = nl;
                r.done = (nl <= 0);
                if (top > {1'b0, ah - 13'd1}) begin
                    r.fail = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== src/skr_cell.sv =====
// One skyline segment cell with its travelling fit candidate.
module skr_cell #(
    parameter int IDX = 0,
    parameter int IW  = 6,
    parameter int CW  = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  skr_pkg::cell_ctl_t  ctl,
    input  logic [IW-1:0]       best,
    input  logic [CW-1:0]       count,
    input  skr_pkg::seg_t       seg_left,
    input  skr_pkg::seg_t       seg_right,
    input  skr_pkg::cand_t      cand_left,
    output skr_pkg::seg_t       seg_o,
    output skr_pkg::cand_t      cand_o,
    output skr_pkg::cell_flag_t flag_o
);
    import skr_pkg::*;

    localparam logic [IW:0] CI = (IW+1)'(IDX);

    seg_t  seg_reg, seg_next;
    cand_t cand_reg, cand_next;
    cand_t init_c;
    logic  my_valid, next_valid, after_best, is_best, is_next, is_prev;

    assign my_valid   = (CW+1)'(IDX) < {1'b0, count};
    always_comb begin
        next_valid = ((CW+1)'(IDX) + 1) < {1'b0, count};
    end
    assign after_best = CI > {1'b0, best};
    assign is_best    = CI == {1'b0, best};
    assign is_next    = CI == ({1'b0, best} + 1'b1);
    assign is_prev    = (CI + 1'b1) == {1'b0, best};

    // Build the candidate that starts at this segment
    always_comb begin
        init_c       = '0;
        init_c.valid = my_valid;
        init_c.fail  = ({2'b00, seg_reg.x} + {1'b0, ctl.req_w}) > {1'b0, ctl.aw - 13'd1};
        init_c.y     = seg_reg.y;
        init_c.left  = $signed({1'b0, ctl.req_w});
        init_c.sx    = seg_reg.x;
        init_c.sw    = seg_reg.w;
    end

    // Select segment and candidate updates for the broadcast operation
    always_comb begin
        seg_next  = seg_reg;
        cand_next = cand_reg;
        case (ctl.op)
            OP_CLEAR: begin
                if (IDX == 0) begin
                    seg_next.x = 12'd1;
                    seg_next.y = 12'd1;
                    seg_next.w = ctl.aw - 13'd2;
                end
            end
            OP_LOAD:  cand_next = cand_step(init_c, seg_reg, my_valid, ctl.req_h, ctl.ah);
            OP_SHIFT: cand_next = cand_step(cand_left, seg_reg, my_valid, ctl.req_h, ctl.ah);
            OP_INSERT: begin
                if (after_best) seg_next = seg_left;
                else if (is_best) seg_next = ctl.new_seg;
            end
            OP_REMOVE: begin
                if (after_best) seg_next = seg_right;
            end
            OP_TRIM: begin
                if (is_next) begin
                    seg_next.x = ctl.edge_pos[COORD_BITS-1:0];
                    seg_next.w = ({1'b0, seg_reg.x} + seg_reg.w) - ctl.edge_pos;
                end
            end
            OP_MERGE_R: begin
                if (after_best) seg_next = seg_right;
                else if (is_best) seg_next.w = seg_reg.w + seg_right.w;
            end
            OP_MERGE_L: begin
                if (after_best || is_best) seg_next = seg_right;
                else if (is_prev) seg_next.w = seg_reg.w + seg_right.w;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn && IDX == 0) begin
            seg_reg.x <= 12'd1;
            seg_reg.y <= 12'd1;
            seg_reg.w <= DIM_RESET - 13'd2;
        end else begin
            seg_reg <= seg_next;
        end
        cand_reg <= cand_next;
    end

    // Report local conditions for the controller
    always_comb begin
        flag_o.trim_hit = is_next && my_valid && ({1'b0, seg_reg.x} < ctl.edge_pos);
        flag_o.covered  = is_next && (({1'b0, seg_reg.x} + seg_reg.w) <= ctl.edge_pos);
        flag_o.eq_next  = is_best && next_valid && (seg_right.y == seg_reg.y);
        flag_o.eq_best  = is_best && (IDX != 0) && (seg_left.y == seg_reg.y);
    end

    assign seg_o  = seg_reg;
    assign cand_o = cand_reg;

endmodule

// ===== src/skyline_rect_allocator_core.sv =====
// Top level: controller, output register and the chain of segment cells.
// From input transfer to result valid: a clear goes through the clear state, a zero width
// straight to decide; no fit or a full table goes load, sweep down the chain, decide;
// a placement adds insert, trim per covered segment, merge right, merge left, finish.
// Throughput: one item at a time; the next is taken the cycle after the result transfer.
// Reset: synchronous active-low; table holds one segment {1, 1, 510}, area zero, both 512.
module skyline_rect_allocator_core #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  skr_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output skr_pkg::out_item_t m_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [12:0]        cfg_wdata
);
    import skr_pkg::*;

    localparam int N  = MAX_SEGMENTS;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLEAR   = 4'd1;
    localparam logic [3:0] S_LOAD    = 4'd2;
    localparam logic [3:0] S_SCAN    = 4'd3;
    localparam logic [3:0] S_DECIDE  = 4'd4;
    localparam logic [3:0] S_INSERT  = 4'd5;
    localparam logic [3:0] S_TRIM    = 4'd6;
    localparam logic [3:0] S_MERGE_R = 4'd7;
    localparam logic [3:0] S_MERGE_L = 4'd8;
    localparam logic [3:0] S_FINISH  = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [IW-1:0]         k_reg, k_next, best_reg, best_next;
    logic [COORD_BITS-1:0] bx_reg, bx_next, by_reg, by_next;
    logic [DIM_BITS:0]     btop_reg, btop_next;
    logic [DIM_BITS-1:0]   bw_reg, bw_next;
    logic                  found_reg, found_next;
    logic [DIM_BITS-1:0]   rw_reg, rw_next, rh_reg, rh_next;
    logic [DIM_BITS-1:0]   aw_reg, ah_reg;
    logic [AREA_BITS-1:0]  area_reg, area_next;
    logic [2*DIM_BITS-1:0] prod_reg, prod_next;
    out_item_t             out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    cell_ctl_t             ctl;
    seg_t                  segs  [N];
    cand_t                 cands [N];
    cell_flag_t            flags [N];
    cell_flag_t            fl;
    cand_t                 tail;
    logic [DIM_BITS:0]     tail_top;
    logic [AREA_BITS+1:0]  area_sum;
    logic [DIM_BITS-1:0]   cfg_val;

    // Clamp a written dimension into its legal range
    always_comb begin
        if (cfg_wdata < DIM_MIN) cfg_val = DIM_MIN;
        else if (cfg_wdata > DIM_MAX) cfg_val = DIM_MAX;
        else cfg_val = cfg_wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aw_reg <= DIM_RESET;
            ah_reg <= DIM_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_WIDTH) aw_reg <= cfg_val;
            else ah_reg <= cfg_val;
        end
    end

    // Cell chain
    for (genvar c = 0; c < N; c++) begin : g_cell
        skr_cell #(.IDX(c), .IW(IW), .CW(CW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .best      (best_reg),
            .count     (count_reg),
            .seg_left  (segs[(c == 0) ? 0 : c - 1]),
            .seg_right (segs[(c == N - 1) ? N - 1 : c + 1]),
            .cand_left ((c == 0) ? cand_t'('0) : cands[(c == 0) ? 0 : c - 1]),
            .seg_o     (segs[c]),
            .cand_o    (cands[c]),
            .flag_o    (flags[c])
        );
    end

    // Gather the flags of the cells around the chosen segment
    always_comb begin
        fl = '0;
        for (int c = 0; c < N; c++) begin
            fl = fl | flags[c];
        end
    end

    assign tail     = cands[N-1];
    assign tail_top = {2'b00, tail.y} + {1'b0, rh_reg};
    assign area_sum = {2'b00, area_reg} + {1'b0, prod_reg};

    // Controller
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        best_next      = best_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        btop_next      = btop_reg;
        bw_next        = bw_reg;
        found_next     = found_reg;
        rw_next        = rw_reg;
        rh_next        = rh_reg;
        area_next      = area_reg;
        prod_next      = prod_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        ctl            = '0;
        ctl.op         = OP_HOLD;
        ctl.edge_pos   = {1'b0, bx_reg} + rw_reg;
        ctl.new_seg.x  = bx_reg;
        ctl.new_seg.y  = by_reg + rh_reg[COORD_BITS-1:0];
        ctl.new_seg.w  = rw_reg;
        ctl.req_w      = rw_reg;
        ctl.req_h      = rh_reg;
        ctl.aw         = aw_reg;
        ctl.ah         = ah_reg;

        // Drop the result once transferred
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    rw_next    = s_data.req_width;
                    rh_next    = s_data.req_height;
                    found_next = 1'b0;
                    k_next     = '0;
                    if (s_data.action) state_next = S_CLEAR;
                    else if (s_data.req_width == '0) state_next = S_DECIDE;
                    else state_next = S_LOAD;
                end
            end
            S_CLEAR: begin
                ctl.op         = OP_CLEAR;
                count_next     = CW'(1);
                area_next      = '0;
                out_next       = '0;
                out_next.status = ST_OK;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_LOAD: begin
                ctl.op     = OP_LOAD;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                // Candidates leave the chain with descending start index
                ctl.op = OP_SHIFT;
                if (tail.valid && tail.done && !tail.fail &&
                    (!found_reg || tail_top < btop_reg ||
                     (tail_top == btop_reg && tail.sw <= bw_reg))) begin
                    found_next = 1'b1;
                    btop_next  = tail_top;
                    bw_next    = tail.sw;
                    bx_next    = tail.sx;
                    by_next    = tail.y;
                    best_next  = IW'(N - 1) - k_reg;
                end
                k_next = k_reg + 1'b1;
                if (k_reg == IW'(N - 1)) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                prod_next = rw_reg * rh_reg;
                if (!found_reg || count_reg >= CW'(N)) begin
                    out_next.status    = found_reg ? ST_FULL : ST_NOFIT;
                    out_next.region_x  = '0;
                    out_next.region_y  = '0;
                    out_next.used_area = area_reg;
                    out_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end else begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT: begin
                ctl.op     = OP_INSERT;
                count_next = count_reg + 1'b1;
                state_next = S_TRIM;
            end
            S_TRIM: begin
                if (fl.trim_hit && fl.covered) begin
                    ctl.op     = OP_REMOVE;
                    count_next = count_reg - 1'b1;
                end else begin
                    if (fl.trim_hit) ctl.op = OP_TRIM;
                    state_next = S_MERGE_R;
                end
            end
            S_MERGE_R: begin
                if (fl.eq_next) begin
                    ctl.op     = OP_MERGE_R;
                    count_next = count_reg - 1'b1;
                end
                state_next = S_MERGE_L;
            end
            S_MERGE_L: begin
                if (fl.eq_best) begin
                    ctl.op     = OP_MERGE_L;
                    count_next = count_reg - 1'b1;
                end
                state_next = S_FINISH;
            end
            S_FINISH: begin
                // Saturate the used area
                area_next = (area_sum > {2'b00, AREA_MAX}) ? AREA_MAX :
                            area_sum[AREA_BITS-1:0];
                out_next.status    = ST_OK;
                out_next.region_x  = bx_reg;
                out_next.region_y  = by_reg;
                out_next.used_area = (area_sum > {2'b00, AREA_MAX}) ? AREA_MAX :
                                     area_sum[AREA_BITS-1:0];
                out_valid_next     = 1'b1;
                state_next         = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= CW'(1);
            area_reg      <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            area_reg      <= area_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
        k_reg    <= k_next;
        best_reg <= best_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        btop_reg <= btop_next;
        bw_reg   <= bw_next;
        rw_reg   <= rw_next;
        rh_reg   <= rh_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    assign s_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the skyline rectangle allocator core.
`timescale 1ns / 1ps

// Placement predictor and result checker for the skyline allocator
class placement_scoreboard;
    localparam int TABLE_DEPTH = 64;

    int          seg_x[TABLE_DEPTH + 1];
    int          seg_y[TABLE_DEPTH + 1];
    int          seg_w[TABLE_DEPTH + 1];
    int          seg_count;
    int unsigned area_total;
    int          atlas_w;
    int          atlas_h;
    skr_pkg::out_item_t expected_placements[$];
    int          mismatches;

    function void power_up();
        atlas_w    = 512;
        atlas_h    = 512;
        mismatches = 0;
        restart_table();
    endfunction

    function void restart_table();
        seg_x[0]   = 1;
        seg_y[0]   = 1;
        seg_w[0]   = atlas_w - 2;
        seg_count  = 1;
        area_total = 0;
    endfunction

    // Append one expected result at the tail of the queue
    function void queue_expected(skr_pkg::out_item_t r);
        expected_placements = {expected_placements, r};
    endfunction

    // Saturate a written dimension into the legal range
    function void write_dim(logic idx, logic [12:0] value);
        int v;
        v = int'(value);
        if (v < 3) v = 3;
        if (v > 4096) v = 4096;
        if (idx == skr_pkg::CFG_WIDTH) atlas_w = v;
        else atlas_h = v;
    endfunction

    // Resting y of a w by h box whose left end is segment idx, -1 if it does not fit
    function int rest_y(int idx, int w, int h);
        int y;
        int left;
        int i;
        y    = seg_y[idx];
        left = w;
        i    = idx;
        if (seg_x[idx] + w > atlas_w - 1) return -1;
        while (left > 0) begin
            if (i >= seg_count) return -1;
            if (seg_y[i] > y) y = seg_y[i];
            if (y + h > atlas_h - 1) return -1;
            left -= seg_w[i];
            i++;
        end
        return y;
    endfunction

    function void drop_segment(int i);
        for (int k = i; k + 1 < seg_count; k++) begin
            seg_x[k] = seg_x[k + 1];
            seg_y[k] = seg_y[k + 1];
            seg_w[k] = seg_w[k + 1];
        end
        seg_count--;
    endfunction

    // Work out the result of one accepted item and queue it
    function void note_input(skr_pkg::in_item_t item);
        skr_pkg::out_item_t r;
        int      w;
        int      h;
        int      best_top;
        int      best_w;
        int      best;
        int      rx;
        int      ry;
        int      y;
        int      i;
        int      edge_x;
        int      k;
        bit      found;
        longint  sum;
        w        = int'(item.req_width);
        h        = int'(item.req_height);
        best_top = 32'h7fffffff;
        best_w   = 32'h7fffffff;
        best     = 0;
        rx       = 0;
        ry       = 0;
        found    = 0;
        r        = '0;
        if (item.action) begin
            restart_table();
            r.status = skr_pkg::ST_OK;
            queue_expected(r);
            return;
        end
        // Sweep every start segment for the lowest top, narrowest on a tie
        if (w > 0) begin
            for (i = 0; i < seg_count; i++) begin
                y = rest_y(i, w, h);
                if (y >= 0 && (y + h < best_top || (y + h == best_top && seg_w[i] < best_w)))
                begin
                    best_top = y + h;
                    best_w   = seg_w[i];
                    best     = i;
                    rx       = seg_x[i];
                    ry       = y;
                    found    = 1;
                end
            end
        end
        r.used_area = 25'(area_total);
        if (!found) begin
            r.status = skr_pkg::ST_NOFIT;
            queue_expected(r);
            return;
        end
        if (seg_count >= TABLE_DEPTH) begin
            r.status = skr_pkg::ST_FULL;
            queue_expected(r);
            return;
        end
        // Insert the new top segment, then trim what it covers
        for (i = seg_count; i > best; i--) begin
            seg_x[i] = seg_x[i - 1];
            seg_y[i] = seg_y[i - 1];
            seg_w[i] = seg_w[i - 1];
        end
        seg_x[best] = rx;
        seg_y[best] = ry + h;
        seg_w[best] = w;
        seg_count++;
        i = best + 1;
        while (i < seg_count) begin
            edge_x = seg_x[i - 1] + seg_w[i - 1];
            if (seg_x[i] >= edge_x) break;
            k = edge_x - seg_x[i];
            seg_x[i] += k;
            seg_w[i] -= k;
            if (seg_w[i] > 0) break;
            drop_segment(i);
        end
        // Merge neighbors of equal height
        i = 0;
        while (i + 1 < seg_count) begin
            if (seg_y[i] == seg_y[i + 1]) begin
                seg_w[i] += seg_w[i + 1];
                drop_segment(i + 1);
            end else begin
                i++;
            end
        end
        sum        = longint'(area_total) + longint'(w) * longint'(h);
        area_total = (sum > 64'h1FFFFFF) ? 32'h1FFFFFF : int'(sum);
        r.status    = skr_pkg::ST_OK;
        r.region_x  = 12'(rx);
        r.region_y  = 12'(ry);
        r.used_area = 25'(area_total);
        queue_expected(r);
    endfunction

    function void check_result(skr_pkg::out_item_t got);
        skr_pkg::out_item_t exp_r;
        if (expected_placements.size() == 0) begin
            $error("unexpected result transfer: %p", got);
            mismatches++;
            return;
        end
        exp_r = expected_placements.pop_front();
        if (got.status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, got.status);
            mismatches++;
        end
        if (got.region_x !== exp_r.region_x) begin
            $error("region_x: expected %0d, actual %0d", exp_r.region_x, got.region_x);
            mismatches++;
        end
        if (got.region_y !== exp_r.region_y) begin
            $error("region_y: expected %0d, actual %0d", exp_r.region_y, got.region_y);
            mismatches++;
        end
        if (got.used_area !== exp_r.used_area) begin
            $error("used_area: expected %0d, actual %0d", exp_r.used_area, got.used_area);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_placements.size();
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 3000000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    skr_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready;
    skr_pkg::out_item_t m_data;
    logic               cfg_we;
    logic               cfg_index;
    logic [12:0]        cfg_wdata;

    placement_scoreboard placements;
    int gap_pct;
    int stall_pct;
    int hold_req;
    int hold_seen;
    int hold_left;
    int cycle_count;

    skyline_rect_allocator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: long hold-off on request, otherwise random stalls
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 800;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) placements.check_result(m_data);
    end

    task automatic write_dim(logic idx, logic [12:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        placements.write_dim(idx, value);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Offer one item; valid stays up between back-to-back transfers
    task automatic send_item(skr_pkg::in_item_t item);
        int gap;
        gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        placements.note_input(item);
    endtask

    // Drop valid, then let the block drain
    task automatic drain();
        s_valid <= 1'b0;
        while (placements.pending() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    function automatic skr_pkg::in_item_t make_item(logic act, int w, int h);
        skr_pkg::in_item_t it;
        it.action     = act;
        it.req_width  = 13'(w);
        it.req_height = 13'(h);
        return it;
    endfunction

    // Random item: mostly small boxes, some narrow tall ones, rare clears and wild sizes
    function automatic skr_pkg::in_item_t random_item();
        int pick;
        int aw;
        int ah;
        pick = $urandom_range(99);
        aw   = placements.atlas_w;
        ah   = placements.atlas_h;
        if (pick < 3) return make_item(1'b1, $urandom_range(4096), $urandom_range(4096));
        if (pick < 9) return make_item(1'b0, $urandom_range(4096), $urandom_range(4096));
        if (pick < 11) return make_item(1'b0, $urandom_range(1), $urandom_range(ah / 4));
        if (pick < 13) return make_item(1'b0, $urandom_range(1, aw / 4 + 1), 0);
        if (pick < 50) return make_item(1'b0, $urandom_range(1, 4), $urandom_range(1, ah / 3 + 1));
        return make_item(1'b0, $urandom_range(1, aw / 6 + 1), $urandom_range(1, ah / 6 + 1));
    endfunction

    initial begin
        int phase_w[8];
        int phase_h[8];
        int phase_n[8];
        placements = new();
        placements.power_up();
        gap_pct     = 0;
        stall_pct   = 0;
        hold_req    = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_we      = 1'b0;
        cfg_index   = skr_pkg::CFG_WIDTH;
        cfg_wdata   = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: clear, zero sizes, extremes, exact fit, overflow of the atlas
        send_item(make_item(1'b1, 4096, 4096));
        send_item(make_item(1'b0, 0, 10));
        send_item(make_item(1'b0, 0, 0));
        send_item(make_item(1'b0, 10, 0));
        send_item(make_item(1'b0, 4096, 4096));
        send_item(make_item(1'b0, 511, 1));
        send_item(make_item(1'b0, 1, 511));
        send_item(make_item(1'b0, 510, 510));
        send_item(make_item(1'b0, 1, 1));
        send_item(make_item(1'b1, 0, 0));
        send_item(make_item(1'b0, 100, 50));
        send_item(make_item(1'b0, 50, 80));
        send_item(make_item(1'b0, 50, 30));
        send_item(make_item(1'b0, 310, 20));
        send_item(make_item(1'b0, 1, 1));
        send_item(make_item(1'b0, 8191 & 4096, 4095));
        drain();

        // Register change without clear: table wider than the new atlas, then shorter
        write_dim(skr_pkg::CFG_WIDTH, 13'd100);
        send_item(make_item(1'b0, 98, 5));
        send_item(make_item(1'b0, 99, 5));
        drain();
        write_dim(skr_pkg::CFG_WIDTH, 13'd1000);
        send_item(make_item(1'b1, 0, 0));
        drain();
        write_dim(skr_pkg::CFG_WIDTH, 13'd2000);
        send_item(make_item(1'b0, 1500, 5));
        send_item(make_item(1'b0, 998, 5));
        drain();

        // Random phases over several atlas sizes and idling patterns
        phase_w = '{512, 3, 4096, 64, 8191, 2, 300, 512};
        phase_h = '{512, 4096, 4096, 3, 40, 8191, 200, 512};
        phase_n = '{200, 60, 150, 100, 150, 60, 200, 230};
        for (int p = 0; p < 8; p++) begin
            write_dim(skr_pkg::CFG_WIDTH, 13'(phase_w[p]));
            write_dim(skr_pkg::CFG_HEIGHT, 13'(phase_h[p]));
            gap_pct   = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 24 : 80) : 0;
            stall_pct = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 3) ? 24 : 80) : 0;
            if (p == 6) hold_req = hold_req + 1;
            if (p % 2 == 0) send_item(make_item(1'b1, 0, 0));
            for (int n = 0; n < phase_n[p]; n++) begin
                send_item(random_item());
                // Pause once mid-phase until everything is back
                if (p == 0 && n == 100) begin
                    s_valid <= 1'b0;
                    while (placements.pending() != 0) @(posedge aclk);
                end
            end
            drain();
        end

        if (placements.mismatches == 0 && placements.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
